// ===== sv/sor_pkg.sv =====
`default_nettype none
package sor_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned WREL_W  = 14;
	localparam logic [15:0] W_ONE   = 16'd16384;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_SOLVE  = 2'd1;
	localparam logic [1:0] REQ_READ   = 2'd2;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam logic [1:0] CFG_GRID  = 2'd0;
	localparam logic [1:0] CFG_ITER  = 2'd1;
	localparam logic [1:0] CFG_RELAX = 2'd2;
	localparam logic [1:0] CFG_TOL   = 2'd3;

	localparam logic KIND_READ   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic signed [31:0] centre;
		logic signed [31:0] west;
		logic signed [31:0] east;
		logic signed [31:0] north;
		logic signed [31:0] south;
		logic signed [31:0] rhs;
	} coef_t;

	typedef struct packed {
		logic        start;
		logic        busy;
		logic        done;
	} div_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) r = 32'sh7fffffff;
		else if (v < -66'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/sor_ram.sv =====
`default_nettype none
module sor_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/sor_div.sv =====
`default_nettype none
module sor_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [31:0] den,
	output logic             busy,
	output logic [63:0]      quo
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [31:0] den_q;
	logic [6:0]  cnt_q;
	logic [64:0] rsh;

	assign rsh  = {rem_q, quo_q[63]};
	assign busy = cnt_q != 7'd0;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 7'd64;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy) begin
			if (rsh >= {33'd0, den_q}) begin
				rem_q <= 64'(rsh - {33'd0, den_q});
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= rsh[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/sor_five_point_grid_solver.sv =====
`default_nettype none
// Load: one word per cycle while idle, no read is pending and the output is not stalled.
// Read: value registered from the solution memory; the next word waits while it is pending.
// Solve: per cell, cell and four neighbor reads, 64-step divider, relax and write back, change
// accumulate; no new word meanwhile. Status word after the last sweep, once the output is free.
// arst_n clears control and registers to their defaults; cell memories are
// undefined until loaded and get no clearing pass.
module sor_five_point_grid_solver #(
	parameter int unsigned GRID_MAX  = 64,
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// req_type[1:0], col[7:2], row[13:8], centre[45:14], west[77:46], east[109:78],
	// north[141:110], south[173:142], rhs[205:174], guess[237:206]
	input  wire logic [239:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// value[31:0], iterations[47:32], converged[48]
	output logic [55:0]       m_tdata,
	// result_kind
	output logic              m_tuser,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import sor_pkg::*;

	localparam int unsigned AW  = 2 * $clog2(GRID_MAX);
	localparam int unsigned RW  = $clog2(GRID_MAX);
	localparam int unsigned NW  = RW + 1;
	localparam int unsigned DEP = 1 << AW;
	localparam int signed   LIMW = 62 - FRAC_BITS;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_RDC   = 11'b00000000010,
		ST_RDW   = 11'b00000000100,
		ST_RDE   = 11'b00000001000,
		ST_RDN   = 11'b00000010000,
		ST_RDS   = 11'b00000100000,
		ST_SUM   = 11'b00001000000,
		ST_DIV   = 11'b00010000000,
		ST_UPD   = 11'b00100000000,
		ST_ACC   = 11'b01000000000,
		ST_OUT   = 11'b10000000000
	} st_t;

	st_t st_q;

	logic [6:0]  grid_q;
	logic [15:0] iter_lim_q;
	logic [15:0] relax_q;
	logic [62:0] tol_q;

	logic [15:0] sweeps_q;
	logic        conv_q, rd_pend_s1, rd_zero_s1;

	logic [1:0]  req;
	logic [5:0]  in_col, in_row;
	logic signed [31:0] in_guess;
	coef_t       in_coef;
	assign req      = s_tdata[1:0];
	assign in_col   = s_tdata[7:2];
	assign in_row   = s_tdata[13:8];
	assign in_coef.centre = s_tdata[45:14];
	assign in_coef.west   = s_tdata[77:46];
	assign in_coef.east   = s_tdata[109:78];
	assign in_coef.north  = s_tdata[141:110];
	assign in_coef.south  = s_tdata[173:142];
	assign in_coef.rhs    = s_tdata[205:174];
	assign in_guess       = s_tdata[237:206];

	logic in_fire, in_range;
	assign in_range = ({26'd0, in_col} < 32'(GRID_MAX)) && ({26'd0, in_row} < 32'(GRID_MAX));
	assign s_tready = (st_q == ST_IDLE) && !rd_pend_s1 && !(m_tvalid && !m_tready);
	assign in_fire  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_q     <= 7'd64;
			iter_lim_q <= 16'd1000;
			relax_q    <= W_ONE;
			tol_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID:  grid_q     <= cfg_data[6:0];
				CFG_ITER:  iter_lim_q <= cfg_data[15:0];
				CFG_RELAX: relax_q    <= cfg_data[15:0];
				CFG_TOL:   tol_q      <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// effective size and limit
	logic [NW-1:0] n_eff;
	logic [15:0]   lim_eff;
	always_comb begin
		if (grid_q < 7'd2) n_eff = NW'(2);
		else if ({25'd0, grid_q} > 32'(GRID_MAX)) n_eff = NW'(GRID_MAX);
		else n_eff = NW'(grid_q);
		lim_eff = (iter_lim_q == 16'd0) ? 16'd1 : iter_lim_q;
	end

	// memories
	logic [AW-1:0] in_addr;
	assign in_addr = {RW'(in_row), RW'(in_col)};
	logic ld_we;
	assign ld_we = in_fire && req == REQ_LOAD && in_range;

	logic [RW-1:0] r_q, c_q;
	logic [AW-1:0] cell_a, sol_raddr, sol_waddr;
	logic          sol_we;
	logic [31:0]   sol_wdata, sol_rdata;
	coef_t         coef_rd;
	assign cell_a = {r_q, c_q};

	sor_ram #(.WIDTH(192), .DEPTH(DEP)) u_coef (
		.clk(clk), .we(ld_we), .waddr(in_addr), .wdata(in_coef),
		.raddr(cell_a), .rdata(coef_rd)
	);
	sor_ram #(.WIDTH(32), .DEPTH(DEP)) u_sol (
		.clk(clk), .we(sol_we), .waddr(sol_waddr), .wdata(sol_wdata),
		.raddr(sol_raddr), .rdata(sol_rdata)
	);

	// neighbor bookkeeping
	logic last_c, last_r;
	assign last_c = ({1'b0, c_q} + NW'(1)) == n_eff;
	assign last_r = (r_q == '0);

	always_comb begin
		sol_raddr = cell_a;
		case (st_q)
			ST_IDLE: sol_raddr = in_addr;
			ST_RDW:  sol_raddr = {r_q, RW'(c_q - RW'(1))};
			ST_RDE:  sol_raddr = {r_q, RW'(c_q + RW'(1))};
			ST_RDN:  sol_raddr = {RW'(r_q + RW'(1)), c_q};
			ST_RDS:  sol_raddr = {RW'(r_q - RW'(1)), c_q};
			default: sol_raddr = cell_a;
		endcase
	end

	logic signed [31:0] old_q, xw_q, xe_q, xn_q;
	coef_t              cf_q;
	logic signed [65:0] sum_q;
	logic signed [63:0] prod;
	logic signed [31:0] pc, px;
	logic               pen;
	logic signed [65:0] term;

	// one neighbor product per state from ST_RDE to ST_SUM
	always_comb begin
		pc = '0; px = sol_rdata; pen = 1'b0;
		case (st_q)
			ST_RDE: begin pc = coef_rd.west;  px = sol_rdata; pen = c_q != '0; end
			ST_RDN: begin pc = cf_q.east;     px = sol_rdata; pen = !last_c; end
			ST_RDS: begin pc = cf_q.north;    px = sol_rdata;
				pen = ({1'b0, r_q} + NW'(1)) != n_eff; end
			ST_SUM: begin pc = cf_q.south;    px = sol_rdata; pen = !last_r; end
			default: ;
		endcase
		prod = pc * px;
		term = pen ? 66'(prod >>> FRAC_BITS) : '0;
	end

	// divider
	logic        div_start, div_busy;
	logic [63:0] div_num, div_quo;
	logic [31:0] div_den;
	logic signed [65:0] s_cl;
	logic        neg_q, czero_q;
	logic signed [65:0] sum_nxt;
	assign sum_nxt = sum_q + term;

	always_comb begin
		s_cl = sum_nxt;
		if (sum_nxt > (66'sd1 <<< LIMW)) s_cl = 66'sd1 <<< LIMW;
		if (sum_nxt < -(66'sd1 <<< LIMW)) s_cl = -(66'sd1 <<< LIMW);
		div_num = 64'((s_cl < 0 ? -s_cl : s_cl) <<< FRAC_BITS);
		div_den = cf_q.centre[31] ? 32'(-cf_q.centre) : cf_q.centre;
	end
	assign div_start = (st_q == ST_SUM);

	sor_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	logic signed [31:0] q_val;
	always_comb begin
		logic [63:0] qm;
		qm = (div_quo > 64'h80000000) ? 64'h80000000 : div_quo;
		if (czero_q)
			q_val = (sum_q > 0) ? 32'sh7fffffff : ((sum_q < 0) ? 32'sh80000000 : '0);
		else
			q_val = sat32(neg_q ? -$signed({2'b0, qm}) : $signed({2'b0, qm}));
	end

	logic signed [65:0] mix;
	logic signed [31:0] nv, nv_q;
	logic signed [32:0] dlt;
	logic [63:0]        sq;
	logic [64:0]        csum_add;
	assign mix = $signed({50'd0, relax_q}) * q_val
		+ ($signed({50'd0, W_ONE}) - $signed({50'd0, relax_q})) * old_q;
	assign nv  = sat32(mix >>> WREL_W);
	assign dlt = 33'(old_q) - 33'(nv_q);
	assign sq  = 64'(33'(dlt[32] ? -dlt : dlt) * 33'(dlt[32] ? -dlt : dlt));
	logic [63:0] csum_q;
	assign csum_add = {1'b0, csum_q} + {1'b0, sq};

	assign sol_we    = ld_we || (st_q == ST_UPD);
	assign sol_waddr = (st_q == ST_UPD) ? cell_a : in_addr;
	assign sol_wdata = (st_q == ST_UPD) ? nv : in_guess;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_RDW: begin cf_q <= coef_rd; old_q <= sol_rdata; sum_q <= 66'(coef_rd.rhs); end
			ST_RDE, ST_RDN, ST_RDS: sum_q <= sum_nxt;
			ST_SUM: begin
				sum_q   <= s_cl;
				czero_q <= cf_q.centre == '0;
				neg_q   <= (s_cl < 0) != cf_q.centre[31];
			end
			ST_UPD: nv_q <= nv;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; r_q <= '0; c_q <= '0; sweeps_q <= '0; csum_q <= '0;
			conv_q <= 1'b0; m_tvalid <= 1'b0; m_tdata <= '0; m_tuser <= 1'b0;
			rd_pend_s1 <= 1'b0; rd_zero_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= in_fire && req == REQ_READ;
			rd_zero_s1 <= !in_range;
			if (rd_pend_s1) begin
				m_tvalid <= 1'b1; m_tuser <= KIND_READ;
				m_tdata  <= {24'd0, rd_zero_s1 ? 32'd0 : sol_rdata};
			end else if (st_q == ST_OUT && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1; m_tuser <= KIND_STATUS;
				m_tdata  <= {7'd0, conv_q, sweeps_q, 32'd0};
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (st_q)
				ST_IDLE: if (in_fire && req == REQ_SOLVE) begin
					st_q <= ST_RDC; r_q <= RW'(n_eff - NW'(1)); c_q <= '0;
					sweeps_q <= 16'd1; csum_q <= '0;
				end
				ST_RDC: st_q <= ST_RDW;
				ST_RDW: st_q <= ST_RDE;
				ST_RDE: st_q <= ST_RDN;
				ST_RDN: st_q <= ST_RDS;
				ST_RDS: st_q <= ST_SUM;
				ST_SUM: st_q <= ST_DIV;
				ST_DIV: if (!div_busy) st_q <= ST_UPD;
				ST_UPD: st_q <= ST_ACC;
				ST_ACC: begin
					csum_q <= csum_add[64] ? '1 : csum_add[63:0];
					st_q <= ST_RDC;
					if (!last_c) c_q <= RW'(c_q + RW'(1));
					else begin
						c_q <= '0;
						if (!last_r) r_q <= RW'(r_q - RW'(1));
						else begin
							r_q <= RW'(n_eff - NW'(1));
							if ((csum_add[64] ? 64'hffffffffffffffff : csum_add[63:0])
								< {1'b0, tol_q}) begin
								conv_q <= 1'b1; st_q <= ST_OUT;
							end else if (sweeps_q >= lim_eff) begin
								conv_q <= 1'b0; st_q <= ST_OUT;
							end else begin
								sweeps_q <= sweeps_q + 16'd1; csum_q <= '0;
							end
						end
					end
				end
				ST_OUT: if (!rd_pend_s1 && (!m_tvalid || m_tready)) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !s_tready)
		else $error("input taken during solve");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_UPD) |-> !div_busy)
		else $error("update before quotient");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT && m_tvalid && m_tready) |=> (m_tvalid && m_tuser == KIND_STATUS))
		else $error("status lost");
endmodule
`default_nettype wire

// ===== dv/sor_five_point_grid_solver_tb.sv =====
`default_nettype none
module sor_five_point_grid_solver_tb;
	import sor_pkg::*;

	typedef struct {
		logic [1:0]  req;
		logic [5:0]  col;
		logic [5:0]  row;
		logic [31:0] centre;
		logic [31:0] west;
		logic [31:0] east;
		logic [31:0] north;
		logic [31:0] south;
		logic [31:0] rhs;
		logic [31:0] guess;
	} grid_req_t;

	typedef struct {
		logic        kind;
		logic [31:0] value;
		logic [15:0] iters;
		logic        conv;
	} grid_result_t;

	typedef struct {
		grid_req_t   item;
		bit          typed;
		logic [31:0] value;
	} directed_row_t;

	typedef struct {
		logic [6:0]  grid;
		logic [15:0] iters;
		logic [15:0] relax;
		logic [63:0] tol;
	} solver_cfg_t;

	localparam int CELLS = 4096;
	localparam int IDLE_LIMIT = 100000;
	localparam logic [63:0] TOL_MAX = 64'h7fff_ffff_ffff_ffff;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [239:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;
	logic         m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [1:0]   cfg_index;
	logic [63:0]  cfg_data;

	sor_five_point_grid_solver dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic signed [31:0] centre_mem [CELLS];
	logic signed [31:0] west_mem [CELLS];
	logic signed [31:0] east_mem [CELLS];
	logic signed [31:0] north_mem [CELLS];
	logic signed [31:0] south_mem [CELLS];
	logic signed [31:0] rhs_mem [CELLS];
	logic signed [31:0] sol_mem [CELLS];
	bit                 loaded [CELLS];

	logic [6:0]     grid_reg;
	logic [15:0]    iter_reg;
	logic [15:0]    relax_reg;
	logic [62:0]    tol_reg;
	logic [63:0]    change_sum;

	grid_result_t   pending_results[$];
	int             errors;
	int             burst_left;
	int             stall_left;
	int             stall_mode;
	int             idle_cycles;

	always #10 clk = ~clk;

	function automatic longint sat_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint quotient(input longint s, input longint c);
		longint lim;
		longint unsigned num, den, q;
		bit neg;
		lim = longint'(1) << 46;
		if (c == 0)
			return s > 0 ? 64'sd2147483647 : (s < 0 ? -64'sd2147483648 : 64'sd0);
		if (s > lim) s = lim;
		if (s < -lim) s = -lim;
		num = longint'(s < 0 ? -s : s) << 16;
		den = c < 0 ? -c : c;
		q = num / den;
		if (q > 64'h8000_0000) q = 64'h8000_0000;
		neg = (s < 0) != (c < 0);
		return sat_word(neg ? -longint'(q) : longint'(q));
	endfunction

	function automatic longint cell_value(input int r, input int c);
		return longint'(sol_mem[r * 64 + c]);
	endfunction

	function automatic void relax_cell(input int r, input int c, input int n);
		int a;
		longint old, s, q, nv, d;
		longint unsigned m;
		logic [64:0] acc;
		a = r * 64 + c;
		old = longint'(sol_mem[a]);
		s = longint'(rhs_mem[a]);
		if (c > 0) s += (longint'(west_mem[a]) * cell_value(r, c - 1)) >>> 16;
		if (c + 1 < n) s += (longint'(east_mem[a]) * cell_value(r, c + 1)) >>> 16;
		if (r + 1 < n) s += (longint'(north_mem[a]) * cell_value(r + 1, c)) >>> 16;
		if (r > 0) s += (longint'(south_mem[a]) * cell_value(r - 1, c)) >>> 16;
		q = quotient(s, longint'(centre_mem[a]));
		nv = longint'(relax_reg) * q + (64'sd16384 - longint'(relax_reg)) * old;
		nv = sat_word(nv >>> 14);
		sol_mem[a] = nv[31:0];
		d = old - nv;
		m = d < 0 ? -d : d;
		acc = {1'b0, change_sum} + {1'b0, m * m};
		change_sum = acc[64] ? 64'hffff_ffff_ffff_ffff : acc[63:0];
	endfunction

	function automatic int grid_span();
		if (grid_reg < 2) return 2;
		if (grid_reg > 64) return 64;
		return grid_reg;
	endfunction

	function automatic grid_result_t solve_grid();
		grid_result_t res;
		int n, lim, sweeps;
		bit conv;
		n = grid_span();
		lim = iter_reg == 0 ? 1 : iter_reg;
		sweeps = 0;
		conv = 0;
		forever begin
			sweeps++;
			change_sum = 0;
			for (int r = n - 1; r >= 0; r--)
				for (int c = 0; c < n; c++)
					relax_cell(r, c, n);
			if (change_sum < {1'b0, tol_reg}) begin
				conv = 1;
				break;
			end
			if (sweeps >= lim) break;
		end
		res.kind = KIND_STATUS;
		res.value = 0;
		res.iters = sweeps[15:0];
		res.conv = conv;
		return res;
	endfunction

	function automatic void record_item(input grid_req_t it, input bit typed,
			input logic [31:0] typed_value);
		grid_result_t res;
		int a;
		a = it.row * 64 + it.col;
		case (it.req)
			REQ_LOAD: begin
				centre_mem[a] = it.centre;
				west_mem[a] = it.west;
				east_mem[a] = it.east;
				north_mem[a] = it.north;
				south_mem[a] = it.south;
				rhs_mem[a] = it.rhs;
				sol_mem[a] = it.guess;
				loaded[a] = 1;
			end
			REQ_SOLVE: pending_results.push_back(solve_grid());
			REQ_READ: begin
				res.kind = KIND_READ;
				res.value = typed ? typed_value : sol_mem[a];
				res.iters = 0;
				res.conv = 0;
				pending_results.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic bit grid_loaded();
		int n;
		n = grid_span();
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!loaded[r * 64 + c]) return 0;
		return 1;
	endfunction

	function automatic logic [31:0] rand_fixed();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 25) return $urandom;
		if (pick < 30) return 32'h7fff_ffff;
		if (pick < 35) return 32'h8000_0000;
		if (pick < 40) return 32'h0;
		return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;
	endfunction

	function automatic grid_req_t mk(input logic [1:0] req, input int col, input int row,
			input logic [31:0] centre, input logic [31:0] west, input logic [31:0] east,
			input logic [31:0] north, input logic [31:0] south, input logic [31:0] rhs,
			input logic [31:0] guess);
		grid_req_t it;
		it.req = req;
		it.col = col[5:0];
		it.row = row[5:0];
		it.centre = centre;
		it.west = west;
		it.east = east;
		it.north = north;
		it.south = south;
		it.rhs = rhs;
		it.guess = guess;
		return it;
	endfunction

	function automatic grid_req_t rand_item();
		grid_req_t it;
		int pick, span;
		span = grid_span() <= 4 ? grid_span() - 1 : 3;
		it = mk(REQ_LOAD, 0, 0, rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed(),
			rand_fixed(), rand_fixed(), rand_fixed());
		if ($urandom_range(0, 9) == 0) it.centre = 0;
		if ($urandom_range(0, 9) < 7) begin
			it.col = 6'($urandom_range(0, span));
			it.row = 6'($urandom_range(0, span));
		end else begin
			it.col = 6'($urandom_range(0, 63));
			it.row = 6'($urandom_range(0, 63));
		end
		pick = $urandom_range(0, 99);
		if (pick < 45)
			it.req = REQ_LOAD;
		else if (pick < 85)
			it.req = loaded[it.row * 64 + it.col] ? REQ_READ : REQ_LOAD;
		else if (pick < 95)
			it.req = (grid_span() <= 4 && grid_loaded()) ? REQ_SOLVE : REQ_LOAD;
		else
			it.req = REQ_UNUSED;
		return it;
	endfunction

	task automatic send_word(input grid_req_t it, input bit typed, input logic [31:0] tv);
		if (burst_left <= 0) begin
			s_tvalid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(0, 7) == 0 ? 200 : $urandom_range(1, 30);
		end
		s_tdata = {2'b0, it.guess, it.rhs, it.south, it.north, it.east, it.west, it.centre,
			it.row, it.col, it.req};
		s_tvalid = 1;
		do @(posedge clk); while (!s_tready);
		record_item(it, typed, tv);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_GRID: grid_reg = data[6:0];
			CFG_ITER: iter_reg = data[15:0];
			CFG_RELAX: relax_reg = data[15:0];
			CFG_TOL: tol_reg = data[62:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic set_config(input solver_cfg_t cfg);
		s_tvalid = 0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		write_reg(CFG_GRID, {57'd0, cfg.grid});
		write_reg(CFG_ITER, {48'd0, cfg.iters});
		write_reg(CFG_RELAX, {48'd0, cfg.relax});
		write_reg(CFG_TOL, cfg.tol);
	endtask

	always @(negedge clk) begin
		if (stall_left <= 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(64, 512);
		end
		stall_left--;
		case (stall_mode)
			0: m_tready = 1;
			1: m_tready = $urandom_range(0, 3) != 0;
			default: m_tready = (stall_left % 7) < 3;
		endcase
	end

	always @(posedge clk) begin
		grid_result_t want;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected word kind=%0b data=%h", $time, m_tuser, m_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.kind || m_tdata[31:0] !== want.value
						|| m_tdata[47:32] !== want.iters || m_tdata[48] !== want.conv) begin
					$display("%0t: mismatch expected kind=%0b value=%h iters=%0d conv=%0b",
						$time, want.kind, want.value, want.iters, want.conv);
					$display("%0t:          actual kind=%0b value=%h iters=%0d conv=%0b",
						$time, m_tuser, m_tdata[31:0], m_tdata[47:32], m_tdata[48]);
					errors++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		directed_row_t dir[$];
		solver_cfg_t phases[8];
		solver_cfg_t cfg;
		grid_req_t it;
		int sent;
		clk = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		m_tready = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		errors = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		idle_cycles = 0;
		grid_reg = 64;
		iter_reg = 1000;
		relax_reg = 16384;
		tol_reg = 0;
		change_sum = 0;
		for (int i = 0; i < CELLS; i++) begin
			loaded[i] = 0;
			sol_mem[i] = 0;
		end

		dir.push_back('{mk(REQ_LOAD, 0, 0, 32'h1_0000, 32'h8000, 32'hffff_8000, 32'h4000,
			32'h0, 32'h2_0000, 32'h7fff_ffff), 0, 0});
		dir.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32'h7fff_ffff});
		dir.push_back('{mk(REQ_LOAD, 0, 1, 32'h0, 32'h1_0000, 0, 0, 32'h1_0000, 32'h3_0000,
			32'h1234), 0, 0});
		dir.push_back('{mk(REQ_LOAD, 1, 0, 32'h0, 0, 0, 0, 0, 32'hfffd_0000,
			32'h8000_0000), 0, 0});
		dir.push_back('{mk(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 32'h8000_0000});
		dir.push_back('{mk(REQ_LOAD, 1, 1, 32'h0, 0, 0, 0, 0, 0, 0), 0, 0});
		dir.push_back('{mk(REQ_UNUSED, 5, 5, 0, 0, 0, 0, 0, 0, 0), 0, 0});
		dir.push_back('{mk(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
		for (int i = 0; i < 4; i++)
			dir.push_back('{mk(REQ_READ, i % 2, i / 2, 0, 0, 0, 0, 0, 0, 0), 0, 0});
		dir.push_back('{mk(REQ_LOAD, 1, 1, 32'h1, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff), 0, 0});
		dir.push_back('{mk(REQ_LOAD, 63, 63, 32'h1_0000, 0, 0, 0, 0, 0, 32'h1234_5678), 0, 0});
		dir.push_back('{mk(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0});
		dir.push_back('{mk(REQ_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0), 1, 32'h1234_5678});
		for (int i = 0; i < 4; i++)
			dir.push_back('{mk(REQ_READ, i % 2, i / 2, 0, 0, 0, 0, 0, 0, 0), 0, 0});

		phases[0] = '{7'd2, 16'd0, 16'd0, 64'd0};
		phases[1] = '{7'd3, 16'd5, 16'd32768, TOL_MAX};
		phases[2] = '{7'($urandom_range(2, 4)), 16'($urandom_range(1, 6)),
			16'($urandom_range(0, 32768)), {$urandom, $urandom} >> 1};
		phases[3] = '{7'd0, 16'd65535, 16'd0, TOL_MAX};
		phases[4] = '{7'd127, 16'd4, 16'd16384, 64'd0};
		phases[5] = '{7'd4, 16'd6, 16'd12000, 64'd0};
		phases[6] = '{7'($urandom_range(2, 4)), 16'($urandom_range(1, 6)),
			16'($urandom_range(0, 32768)), {24'd0, $urandom, 8'($urandom)}};
		phases[7] = '{7'd2, 16'd1, 16'd20000, TOL_MAX};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		cfg = '{7'd1, 16'd3, 16'd16384, 64'd0};
		set_config(cfg);
		foreach (dir[i])
			send_word(dir[i].item, dir[i].typed, dir[i].value);
		cfg = '{7'd2, 16'd1, 16'd16384, TOL_MAX};
		set_config(cfg);
		it = mk(REQ_SOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		send_word(it, 0, 0);

		foreach (phases[p]) begin
			set_config(phases[p]);
			sent = 0;
			while (sent < 225) begin
				it = rand_item();
				send_word(it, 0, 0);
				if (it.req != REQ_UNUSED) sent++;
			end
		end
		s_tvalid = 0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
sv/sor_pkg.sv
sv/sor_ram.sv
sv/sor_div.sv
sv/sor_five_point_grid_solver.sv
dv/sor_five_point_grid_solver_tb.sv
